// ----- hdl/running_median_two_heaps_defines.svh -----
// Assertion macros for the running median block.
// Used by the port checker; needs no other file.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_DEFINES_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define RMTH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a condition in the cycle after its trigger
`define RMTH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/rmth_pkg.sv -----
// Shared types for the running median block.
// No dependencies.
package rmth_pkg;

   localparam int SampleWidth = 32;
   localparam int MedianWidth = 33;
   localparam int CountWidth  = 10;

   typedef enum logic [2:0] {
      HP_IDLE, HP_UP, HP_UP_CMP, HP_POP_LAST, HP_DN, HP_DN_L, HP_DN_R
   } heap_state_type;

   typedef enum logic [1:0] {MS_IDLE, MS_INS, MS_BAL, MS_OUT} main_state_type;

   typedef enum logic [1:0] {SEL_SELF, SEL_LEFT, SEL_RIGHT} child_sel_type;

   typedef struct packed {
      logic                          push;
      logic                          pop;
      logic signed [SampleWidth-1:0] data;
   } heap_cmd_type;

   typedef struct packed {
      logic                          busy;
      logic signed [SampleWidth-1:0] top;
   } heap_status_type;

endpackage

// ----- hdl/rmth_heap.sv -----
// One binary heap in a single-port-write memory with a shared comparator.
// Depends on rmth_pkg.
module rmth_heap #(
   parameter int CAPACITY = 512
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     max_mode,
   input  rmth_pkg::heap_cmd_type   cmd,
   output rmth_pkg::heap_status_type status,
   output logic [$clog2(CAPACITY+1)-1:0] count
);
   import rmth_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic signed [SampleWidth-1:0] mem [CAPACITY];
   logic signed [SampleWidth-1:0] rd_data_ff, top_ff;
   heap_state_type state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic signed [SampleWidth-1:0] val_ff, val_in, best_ff, best_in;
   child_sel_type bsel_ff, bsel_in;
   logic we, re;
   logic [AW-1:0] wa, ra;
   logic signed [SampleWidth-1:0] wd, cmp_a, cmp_b;
   logic win;
   logic [AW+1:0] lft, rgt, n_wide;
   logic act_go;
   child_sel_type act_sel;
   logic signed [SampleWidth-1:0] act_val;

   assign lft    = (AW+2)'({idx_ff, 1'b1});
   assign rgt    = lft + 1'b1;
   assign n_wide = (AW+2)'(cnt_ff);
   assign win    = max_mode ? (cmp_a > cmp_b) : (cmp_a < cmp_b);

   assign status.busy = (state_ff != HP_IDLE);
   assign status.top  = top_ff;
   assign count       = cnt_ff;

   // Next state, memory access and the shared compare
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      val_in   = val_ff;
      best_in  = best_ff;
      bsel_in  = bsel_ff;
      we = 1'b0; wa = idx_ff; wd = val_ff;
      re = 1'b0; ra = '0;
      cmp_a = rd_data_ff; cmp_b = val_ff;
      act_go = 1'b0; act_sel = SEL_SELF; act_val = val_ff;
      unique case (state_ff)
         HP_IDLE: begin
            if (cmd.push) begin
               idx_in   = AW'(cnt_ff);
               val_in   = cmd.data;
               cnt_in   = cnt_ff + 1'b1;
               state_in = HP_UP;
            end else if (cmd.pop) begin
               cnt_in   = cnt_ff - 1'b1;
               re       = 1'b1;
               ra       = AW'(cnt_ff - 1'b1);
               state_in = HP_POP_LAST;
            end
         end
         HP_UP: begin
            if (idx_ff == '0) begin
               we = 1'b1;
               state_in = HP_IDLE;
            end else begin
               re = 1'b1;
               ra = AW'((idx_ff - 1'b1) >> 1);
               state_in = HP_UP_CMP;
            end
         end
         HP_UP_CMP: begin
            cmp_a = val_ff;
            cmp_b = rd_data_ff;
            we = 1'b1;
            if (win) begin
               wd       = rd_data_ff;
               idx_in   = AW'((idx_ff - 1'b1) >> 1);
               state_in = HP_UP;
            end else begin
               state_in = HP_IDLE;
            end
         end
         HP_POP_LAST: begin
            val_in   = rd_data_ff;
            idx_in   = '0;
            state_in = HP_DN;
         end
         HP_DN: begin
            if (lft >= n_wide) begin
               we = 1'b1;
               state_in = HP_IDLE;
            end else begin
               re = 1'b1;
               ra = lft[AW-1:0];
               state_in = HP_DN_L;
            end
         end
         HP_DN_L: begin
            if (rgt < n_wide) begin
               best_in  = win ? rd_data_ff : val_ff;
               bsel_in  = win ? SEL_LEFT : SEL_SELF;
               re       = 1'b1;
               ra       = rgt[AW-1:0];
               state_in = HP_DN_R;
            end else begin
               act_go  = 1'b1;
               act_sel = win ? SEL_LEFT : SEL_SELF;
               act_val = win ? rd_data_ff : val_ff;
            end
         end
         HP_DN_R: begin
            cmp_b   = best_ff;
            act_go  = 1'b1;
            act_sel = win ? SEL_RIGHT : bsel_ff;
            act_val = win ? rd_data_ff : best_ff;
         end
         default: state_in = HP_IDLE;
      endcase

      // Fill the hole with the winner and descend, or settle the carried value
      if (act_go) begin
         we = 1'b1;
         wd = act_val;
         case (act_sel)
            SEL_LEFT: begin
               idx_in   = lft[AW-1:0];
               state_in = HP_DN;
            end
            SEL_RIGHT: begin
               idx_in   = rgt[AW-1:0];
               state_in = HP_DN;
            end
            default: begin
               wd       = val_ff;
               state_in = HP_IDLE;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HP_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      val_ff  <= val_in;
      best_ff <= best_in;
      bsel_ff <= bsel_in;
      if (we && wa == '0) begin
         top_ff <= wd;
      end
   end

   // Heap store
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (re) begin
         rd_data_ff <= mem[ra];
      end
   end

endmodule

// ----- hdl/running_median_two_heaps.sv -----
// Running median of signed samples: a max-heap for the lower half and a
// min-heap for the upper half. Each accepted item gives one result item with
// twice the median (one fractional bit), the sample count and a drop flag.
// Channels: req_valid/req_stall carries req_sample in; rsp_valid/rsp_stall
// carries the result out. An item is taken when valid is high and stall low.
// A dropped item (store holds 2*CAPACITY-1 samples) shows its result in
// the next cycle. Otherwise one heap insert, then at most one pop and one
// push running in parallel on the two heaps. Each heap walks one level at
// a time, going up or going down, with at most one memory read per cycle.
// One item is in flight at a time; req_stall is high while it is at work.
// A result waits in the output register while rsp_stall is high, and
// req_stall stays high until that result is taken.
// Reset empties both heaps; the first result then reports the new sample.
module running_median_two_heaps #(
   parameter int CAPACITY = 512
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [rmth_pkg::SampleWidth-1:0] req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [rmth_pkg::MedianWidth-1:0] rsp_median_times_two,
   output logic [rmth_pkg::CountWidth-1:0]      rsp_sample_count,
   output logic                                 rsp_dropped
);
   import rmth_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   main_state_type state_ff, state_in;
   heap_cmd_type lcmd, ucmd;
   heap_status_type lst, ust;
   logic [CW-1:0] lcnt, ucnt;
   logic [CW:0] total;
   logic drop, accept, out_free, load_out;
   logic signed [MedianWidth-1:0] median;
   logic rsp_valid_ff;
   logic signed [MedianWidth-1:0] med_ff;
   logic [CountWidth-1:0] cnt_ff;
   logic drop_ff;

   rmth_heap #(.CAPACITY(CAPACITY)) u_lower (
      .clock(clock), .reset(reset), .max_mode(1'b1),
      .cmd(lcmd), .status(lst), .count(lcnt)
   );
   rmth_heap #(.CAPACITY(CAPACITY)) u_upper (
      .clock(clock), .reset(reset), .max_mode(1'b0),
      .cmd(ucmd), .status(ust), .count(ucnt)
   );

   assign total    = {1'b0, lcnt} + {1'b0, ucnt};
   assign drop     = total >= (CW+1)'(2 * CAPACITY - 1);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != MS_IDLE) || !out_free;
   assign accept   = req_valid && !req_stall;

   // Median from the two tops
   always_comb begin
      if (lcnt == '0) begin
         median = '0;
      end else if (lcnt == ucnt) begin
         median = {lst.top[SampleWidth-1], lst.top} + {ust.top[SampleWidth-1], ust.top};
      end else begin
         median = {lst.top, 1'b0};
      end
   end

   // Sequencer: insert, rebalance, report
   always_comb begin
      state_in = state_ff;
      lcmd = '0;
      ucmd = '0;
      load_out = 1'b0;
      unique case (state_ff)
         MS_IDLE: begin
            if (accept) begin
               if (drop) begin
                  load_out = 1'b1;
               end else begin
                  if (lcnt == '0 || req_sample <= lst.top) begin
                     lcmd.push = 1'b1;
                     lcmd.data = req_sample;
                  end else begin
                     ucmd.push = 1'b1;
                     ucmd.data = req_sample;
                  end
                  state_in = MS_INS;
               end
            end
         end
         MS_INS: begin
            if (!lst.busy && !ust.busy) begin
               if ({1'b0, lcnt} > {1'b0, ucnt} + 1'b1) begin
                  lcmd.pop  = 1'b1;
                  ucmd.push = 1'b1;
                  ucmd.data = lst.top;
                  state_in  = MS_BAL;
               end else if (ucnt > lcnt) begin
                  ucmd.pop  = 1'b1;
                  lcmd.push = 1'b1;
                  lcmd.data = ust.top;
                  state_in  = MS_BAL;
               end else begin
                  state_in = MS_OUT;
               end
            end
         end
         MS_BAL: begin
            if (!lst.busy && !ust.busy) begin
               state_in = MS_OUT;
            end
         end
         MS_OUT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = MS_IDLE;
            end
         end
         default: state_in = MS_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= MS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the result item
   always_ff @(posedge clock) begin
      if (load_out) begin
         med_ff  <= median;
         cnt_ff  <= CountWidth'(total);
         drop_ff <= (state_ff == MS_IDLE);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_median_times_two = med_ff;
   assign rsp_sample_count     = cnt_ff;
   assign rsp_dropped          = drop_ff;

endmodule

// ----- hdl/rmth_checker.sv -----
// Port checker for the running median block, bound to the top level.
// Depends on rmth_pkg and running_median_two_heaps_defines.svh.
`include "running_median_two_heaps_defines.svh"

module rmth_checker #(
   parameter int CAPACITY = 512
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [rmth_pkg::MedianWidth-1:0] rsp_median_times_two,
   input logic [rmth_pkg::CountWidth-1:0]      rsp_sample_count,
   input logic                                 rsp_dropped
);
   import rmth_pkg::*;

   localparam logic [CountWidth-1:0] FullCount = CountWidth'(2 * CAPACITY - 1);

   // Hold a stalled result item
   `RMTH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")
   // A drop happens only at a full store
   `RMTH_ASSERT_NOW(a_drop_full, clock, reset, rsp_valid && rsp_dropped, rsp_sample_count == FullCount, "drop below full")
   // Empty store reports zero
   `RMTH_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && rsp_sample_count == '0 && !rsp_dropped, rsp_median_times_two == '0, "nonzero median when empty")
   // Odd count gives twice one sample, an even value
   `RMTH_ASSERT_NOW(a_odd_even, clock, reset, rsp_valid && rsp_sample_count[0], !rsp_median_times_two[0], "odd median for odd count")

endmodule

bind running_median_two_heaps rmth_checker #(.CAPACITY(CAPACITY)) u_rmth_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_median_times_two(rsp_median_times_two), .rsp_sample_count(rsp_sample_count),
   .rsp_dropped(rsp_dropped)
);

// ----- tb/sv/median_checker.sv -----
// Checker for the running median block: watches both channels, predicts
// each result with its own two-heap model and compares field by field.
// Depends on rmth_pkg for field widths.
`timescale 1ns / 1ps

module median_checker #(
   parameter int CAPACITY = 512
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic signed [rmth_pkg::SampleWidth-1:0] req_sample,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic signed [rmth_pkg::MedianWidth-1:0] rsp_median_times_two,
   input  logic [rmth_pkg::CountWidth-1:0]         rsp_sample_count,
   input  logic                                    rsp_dropped,
   output int                                      fail_count,
   output int                                      pending_count
);
   import rmth_pkg::*;

   typedef struct packed {
      logic signed [MedianWidth-1:0] median2;
      logic [CountWidth-1:0]         count;
      logic                          dropped;
   } median_result_type;

   // model state: lower half max-heap, upper half min-heap
   logic signed [SampleWidth-1:0] lo_heap [CAPACITY];
   logic signed [SampleWidth-1:0] hi_heap [CAPACITY];
   int unsigned lo_n, hi_n;
   median_result_type expected_results [$];

   function automatic bit ranks_above(bit is_max, logic signed [SampleWidth-1:0] a,
                                      logic signed [SampleWidth-1:0] b);
      return is_max ? (a > b) : (a < b);
   endfunction

   task automatic push_lo(logic signed [SampleWidth-1:0] v);
      int unsigned i;
      int unsigned p;
      logic signed [SampleWidth-1:0] t;
      i = lo_n;
      lo_heap[i] = v;
      lo_n++;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!ranks_above(1, lo_heap[i], lo_heap[p])) break;
         t = lo_heap[p]; lo_heap[p] = lo_heap[i]; lo_heap[i] = t;
         i = p;
      end
   endtask

   task automatic push_hi(logic signed [SampleWidth-1:0] v);
      int unsigned i;
      int unsigned p;
      logic signed [SampleWidth-1:0] t;
      i = hi_n;
      hi_heap[i] = v;
      hi_n++;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!ranks_above(0, hi_heap[i], hi_heap[p])) break;
         t = hi_heap[p]; hi_heap[p] = hi_heap[i]; hi_heap[i] = t;
         i = p;
      end
   endtask

   // pop the top of one heap and sift the last entry down
   task automatic pop_top(bit is_max, output logic signed [SampleWidth-1:0] top);
      int unsigned n, i, l, r, best;
      logic signed [SampleWidth-1:0] t;
      if (is_max) begin
         top = lo_heap[0]; lo_n--; n = lo_n; lo_heap[0] = lo_heap[n];
      end else begin
         top = hi_heap[0]; hi_n--; n = hi_n; hi_heap[0] = hi_heap[n];
      end
      i = 0;
      forever begin
         l = 2 * i + 1; r = 2 * i + 2; best = i;
         if (is_max) begin
            if (l < n && ranks_above(1, lo_heap[l], lo_heap[best])) best = l;
            if (r < n && ranks_above(1, lo_heap[r], lo_heap[best])) best = r;
            if (best == i) break;
            t = lo_heap[i]; lo_heap[i] = lo_heap[best]; lo_heap[best] = t;
         end else begin
            if (l < n && ranks_above(0, hi_heap[l], hi_heap[best])) best = l;
            if (r < n && ranks_above(0, hi_heap[r], hi_heap[best])) best = r;
            if (best == i) break;
            t = hi_heap[i]; hi_heap[i] = hi_heap[best]; hi_heap[best] = t;
         end
         i = best;
      end
   endtask

   task automatic add_sample(logic signed [SampleWidth-1:0] s);
      median_result_type res;
      logic signed [SampleWidth-1:0] x;
      res.dropped = (lo_n + hi_n) >= (2 * CAPACITY - 1);
      if (!res.dropped) begin
         // equal to the lower top goes low
         if (lo_n == 0 || s <= lo_heap[0]) push_lo(s);
         else push_hi(s);
         if (lo_n > hi_n + 1) begin
            pop_top(1, x); push_hi(x);
         end else if (hi_n > lo_n) begin
            pop_top(0, x); push_lo(x);
         end
      end
      if (lo_n == 0) res.median2 = '0;
      else if (lo_n == hi_n)
         res.median2 = MedianWidth'(lo_heap[0]) + MedianWidth'(hi_heap[0]);
      else res.median2 = MedianWidth'(lo_heap[0]) <<< 1;
      res.count = CountWidth'(lo_n + hi_n);
      expected_results.push_back(res);
   endtask

   // predict on accepted inputs, compare accepted outputs
   always @(posedge clock) begin
      median_result_type want;
      if (reset) begin
         lo_n = 0; hi_n = 0;
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall) add_sample(req_sample);
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result item");
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_median_times_two !== want.median2) begin
                  $error("median_times_two expected %0d actual %0d",
                         want.median2, rsp_median_times_two);
                  fail_count++;
               end
               if (rsp_sample_count !== want.count) begin
                  $error("sample_count expected %0d actual %0d",
                         want.count, rsp_sample_count);
                  fail_count++;
               end
               if (rsp_dropped !== want.dropped) begin
                  $error("dropped expected %0d actual %0d", want.dropped, rsp_dropped);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the running median testbench: clock, reset, sample stimulus and
// receiver stalls. Depends on rmth_pkg, the block and median_checker.
`timescale 1ns / 1ps

module tb_top;
   import rmth_pkg::*;

   localparam int CAPACITY = 512;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [SampleWidth-1:0] req_sample;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [MedianWidth-1:0] rsp_median_times_two;
   logic [CountWidth-1:0] rsp_sample_count;
   logic rsp_dropped;
   int fail_count;
   int pending_count;

   running_median_two_heaps #(.CAPACITY(CAPACITY)) dut (.*);

   median_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // receiver stall pattern: quiet stretches, then random stalls
   initial begin
      int stall_mode;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         stall_mode = ($urandom_range(0, 199) < 2) ? $urandom_range(0, 2) : stall_mode;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   // offer one item and hold it until taken
   task automatic send_sample(logic signed [SampleWidth-1:0] s);
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic go_idle(int cycles);
      req_valid <= 1'b0;
      req_sample <= SampleWidth'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   function automatic logic signed [SampleWidth-1:0] rand_sample(int pick);
      case (pick)
         0: return $signed(32'h7FFF_FFFF - $urandom_range(0, 3));
         1: return $signed(32'h8000_0000 + $urandom_range(0, 3));
         2: return $signed($urandom_range(0, 20)) - 10;
         default: return $signed($urandom);
      endcase
   endfunction

   initial begin
      int burst;
      int wait_cycles;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, ties, mixed signs
      send_sample(32'sh7FFF_FFFF);
      send_sample(32'sh7FFF_FFFF);
      send_sample(32'sh8000_0000);
      send_sample(32'sh8000_0000);
      send_sample(32'sh8000_0000);
      send_sample(0);
      send_sample(0);
      send_sample(-1);
      send_sample(1);
      send_sample(32'sh5555_5555);
      send_sample(32'shAAAA_AAAA);
      send_sample(32'sh7FFF_FFFF);
      go_idle(3);

      // random bursts; the long fill runs the store into the full case
      for (int n = 0; n < 1350; ) begin
         burst = $urandom_range(1, 20);
         for (int k = 0; k < burst; k++) begin
            send_sample(rand_sample($urandom_range(0, 5)));
            n++;
         end
         if ($urandom_range(0, 2) != 0) go_idle($urandom_range(0, 60));
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("running_median_two_heaps regression: pass");
      else
         $display("running_median_two_heaps regression: fail");
      $finish;
   end

   initial begin
      #1_500_000;
      $display("running_median_two_heaps regression: fail");
      $finish;
   end

endmodule
